[sv/amf3_pkg.sv]
// Shared types and constants of the AMF3 scalar value decoder.
package amf3_pkg;

	localparam int DATA_W = 8;
	localparam int INT_W  = 29;
	localparam int DBL_W  = 64;
	localparam int KIND_W = 3;
	localparam int CNT_W  = 3;

	// Width of the result beat, padded up to whole bytes.
	localparam int RES_W  = KIND_W + INT_W + DBL_W;
	localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

	localparam logic [DATA_W-1:0] MARK_FALSE = 8'h02;
	localparam logic [DATA_W-1:0] MARK_TRUE  = 8'h03;
	localparam logic [DATA_W-1:0] MARK_INT   = 8'h04;
	localparam logic [DATA_W-1:0] MARK_DBL   = 8'h05;

	// U29 groups before the full-byte group.
	localparam logic [CNT_W-1:0] U29_GROUPS = 3'd3;
	// Index of the last payload byte of a double.
	localparam logic [CNT_W-1:0] DBL_LAST   = 3'd7;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_INT  = 2'd1,
		PH_DBL  = 2'd2,
		PH_SKIP = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NIL    = 3'd0,
		KIND_FALSE  = 3'd1,
		KIND_TRUE   = 3'd2,
		KIND_INT    = 3'd3,
		KIND_DOUBLE = 3'd4
	} kind_t;

	typedef struct packed {
		logic             cut_short;
		logic [DBL_W-1:0] double_bits;
		logic [INT_W-1:0] int_value;
		kind_t            value_kind;
	} result_t;

endpackage

[sv/amf3_core.sv]
// Decode state machine and accumulators: one message byte per enabled cycle.
module amf3_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [amf3_pkg::DATA_W-1:0]   data_byte,
	input  logic                          last_byte,
	output logic                          res_valid,
	output amf3_pkg::result_t             res
);

	amf3_pkg::phase_t              phase_q, phase_d;
	logic [amf3_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [amf3_pkg::INT_W-1:0]    int_q, int_d, int_shift;
	logic [amf3_pkg::DBL_W-1:0]    dbl_q, dbl_d, dbl_shift;
	logic                          int_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= amf3_pkg::PH_TYPE;
			cnt_q   <= '0;
			int_q   <= '0;
			dbl_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			int_q   <= int_d;
			dbl_q   <= dbl_d;
		end
	end

	always_comb begin
		// Early groups carry 7 bits; the fourth byte carries all 8.
		if (cnt_q < amf3_pkg::U29_GROUPS) begin
			int_shift = {int_q[amf3_pkg::INT_W-8:0], data_byte[6:0]};
			int_done  = !data_byte[7];
		end else begin
			int_shift = {int_q[amf3_pkg::INT_W-9:0], data_byte};
			int_done  = 1'b1;
		end
		dbl_shift = {dbl_q[amf3_pkg::DBL_W-9:0], data_byte};
	end

	always_comb begin
		phase_d         = phase_q;
		cnt_d           = cnt_q;
		int_d           = int_q;
		dbl_d           = dbl_q;
		res_valid       = 1'b0;
		res.value_kind  = amf3_pkg::KIND_NIL;
		res.int_value   = '0;
		res.double_bits = '0;
		res.cut_short   = 1'b0;

		case (phase_q)
			amf3_pkg::PH_TYPE: begin
				cnt_d = '0;
				int_d = '0;
				dbl_d = '0;
				if (data_byte == amf3_pkg::MARK_INT || data_byte == amf3_pkg::MARK_DBL) begin
					if (last_byte) begin
						res_valid     = 1'b1;
						res.cut_short = 1'b1;
					end else begin
						phase_d = (data_byte == amf3_pkg::MARK_INT) ?
							amf3_pkg::PH_INT : amf3_pkg::PH_DBL;
					end
				end else begin
					res_valid = 1'b1;
					if (data_byte == amf3_pkg::MARK_FALSE)
						res.value_kind = amf3_pkg::KIND_FALSE;
					else if (data_byte == amf3_pkg::MARK_TRUE)
						res.value_kind = amf3_pkg::KIND_TRUE;
					phase_d = last_byte ? amf3_pkg::PH_TYPE : amf3_pkg::PH_SKIP;
				end
			end
			amf3_pkg::PH_INT: begin
				cnt_d = cnt_q + amf3_pkg::CNT_W'(1);
				int_d = int_shift;
				if (int_done) begin
					res_valid      = 1'b1;
					res.value_kind = amf3_pkg::KIND_INT;
					res.int_value  = int_shift;
					phase_d        = last_byte ? amf3_pkg::PH_TYPE : amf3_pkg::PH_SKIP;
				end else if (last_byte) begin
					res_valid     = 1'b1;
					res.cut_short = 1'b1;
					phase_d       = amf3_pkg::PH_TYPE;
				end
			end
			amf3_pkg::PH_DBL: begin
				cnt_d = cnt_q + amf3_pkg::CNT_W'(1);
				dbl_d = dbl_shift;
				if (cnt_q == amf3_pkg::DBL_LAST) begin
					res_valid       = 1'b1;
					res.value_kind  = amf3_pkg::KIND_DOUBLE;
					res.double_bits = dbl_shift;
					phase_d         = last_byte ? amf3_pkg::PH_TYPE : amf3_pkg::PH_SKIP;
				end else if (last_byte) begin
					res_valid     = 1'b1;
					res.cut_short = 1'b1;
					phase_d       = amf3_pkg::PH_TYPE;
				end
			end
			amf3_pkg::PH_SKIP: begin
				if (last_byte)
					phase_d = amf3_pkg::PH_TYPE;
			end
			default: begin
				phase_d = amf3_pkg::PH_TYPE;
			end
		endcase

		// Drop the accumulators whenever a message's value is settled.
		if (res_valid || phase_d == amf3_pkg::PH_SKIP) begin
			cnt_d = '0;
			int_d = '0;
			dbl_d = '0;
		end
	end

endmodule

[sv/amf3_scalar_value_decoder.sv]
// Top level of the AMF3 scalar value decoder: input stage, decode core, result register.
//
// The decoder takes a serialized AMF3 message one byte per beat on the s_ side, with
// s_tlast on the final byte, and returns one result beat per message for its first
// value: nil, false, true, a U29 integer or the raw 64 bits of a double. Bytes after
// the value are skipped up to the end of the message. A message that ends inside an
// integer or double gives nil with m_tuser (cut_short) set. Throughput is one byte
// per clock cycle while the decode step is not stalled. A byte is registered in the
// input stage, and when it settles a value its result loads into the result register
// and shows on m_tvalid. A single combinational decode step lies between those two
// registers. Backpressure on m_tready stalls the decode step once the result register
// holds a beat that has not been taken; the byte in the input stage then waits,
// whether or not it settles a value, and s_tready stays low while that stage is
// occupied and the result beat is not drained.
module amf3_scalar_value_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,  // [7:0] data_byte
	input  logic                                 s_tlast,  // last_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [amf3_pkg::TDATA_OUT_W-1:0]     m_tdata,  // [2:0] value_kind,
	                                                       // [31:3] int_value,
	                                                       // [95:32] double_bits
	output logic                                 m_tuser   // cut_short
);

	logic                          valid_s1;
	logic [amf3_pkg::DATA_W-1:0]   byte_s1;
	logic                          last_s1;
	logic                          adv;
	logic                          core_en;
	logic                          res_valid;
	amf3_pkg::result_t             res;
	logic                          out_valid_q;
	amf3_pkg::result_t             out_q;

	// Advance the decode step whenever the result register is free or being drained.
	assign adv      = !out_valid_q || m_tready;
	assign core_en  = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// Input stage: hold the byte until the core can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	amf3_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (core_en),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: load a settled value, clear once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= core_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = amf3_pkg::TDATA_OUT_W'({out_q.double_bits, out_q.int_value,
		out_q.value_kind});
	assign m_tuser  = out_q.cut_short;

endmodule

[sv/amf3_checker.sv]
// Port-level checks of the AMF3 scalar value decoder, bound to its top level.
module amf3_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [amf3_pkg::TDATA_OUT_W-1:0]  m_tdata,
	input logic                              m_tuser
);

	// Hold a result beat until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// A cut-short message reports nil with empty payload.
	a_cut_nil: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == amf3_pkg::KIND_NIL &&
		m_tdata[95:3] == '0)
		else $error("cut-short result carries a value");

	// Integer field is zero unless the kind is integer.
	a_int_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != amf3_pkg::KIND_INT |-> m_tdata[31:3] == '0)
		else $error("integer field set on non-integer result");

	// Double field is zero unless the kind is double.
	a_dbl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != amf3_pkg::KIND_DOUBLE |-> m_tdata[95:32] == '0)
		else $error("double field set on non-double result");

endmodule

bind amf3_scalar_value_decoder amf3_checker u_amf3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/amf3_scalar_value_decoder_tb.sv]
// Self-checking testbench of the AMF3 scalar value decoder with a message-level scoreboard.
module amf3_scalar_value_decoder_tb;
	import amf3_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int IDLE_LIMIT  = 3000;  // cycles with no beat on either side
	localparam int DRAIN_CYCLES = 8;    // slack after the scoreboard is empty
	localparam int RANDOM_BYTES = 600;

	// Predicts the decoded value of each message and holds the values still to come.
	class decoded_value_book;
		phase_t           cur_phase;
		logic [CNT_W-1:0] payload_cnt;
		logic [INT_W-1:0] u29_acc;
		logic [DBL_W-1:0] dbl_acc;
		result_t          pending_values[$];
		int               mismatches;

		function new();
			cur_phase   = PH_TYPE;
			payload_cnt = '0;
			u29_acc     = '0;
			dbl_acc     = '0;
			mismatches  = 0;
		endfunction

		function int pending_count();
			return pending_values.size();
		endfunction

		// Queue the value and either wait for the next marker or skip the rest.
		function void settle(result_t r, logic last);
			pending_values.push_back(r);
			cur_phase   = last ? PH_TYPE : PH_SKIP;
			payload_cnt = '0;
			u29_acc     = '0;
			dbl_acc     = '0;
		endfunction

		// Note one accepted input byte.
		function void take_byte(logic [DATA_W-1:0] b, logic last);
			result_t r;
			bit      done;
			r = '0;
			r.value_kind = KIND_NIL;
			case (cur_phase)
				PH_TYPE: begin
					payload_cnt = '0;
					u29_acc     = '0;
					dbl_acc     = '0;
					if (b == MARK_INT || b == MARK_DBL) begin
						if (last) begin
							// marker alone ends the message: truncated
							r.cut_short = 1'b1;
							settle(r, 1'b1);
						end else begin
							cur_phase = (b == MARK_INT) ? PH_INT : PH_DBL;
						end
					end else begin
						if (b == MARK_FALSE)
							r.value_kind = KIND_FALSE;
						else if (b == MARK_TRUE)
							r.value_kind = KIND_TRUE;
						settle(r, last);
					end
				end
				PH_INT: begin
					if (payload_cnt < U29_GROUPS) begin
						u29_acc = {u29_acc[INT_W-8:0], b[6:0]};
						done    = !b[7];
					end else begin
						// fourth byte carries all eight bits
						u29_acc = {u29_acc[INT_W-9:0], b};
						done    = 1'b1;
					end
					payload_cnt = payload_cnt + CNT_W'(1);
					if (done) begin
						r.value_kind = KIND_INT;
						r.int_value  = u29_acc;
						settle(r, last);
					end else if (last) begin
						r.cut_short = 1'b1;
						settle(r, 1'b1);
					end
				end
				PH_DBL: begin
					dbl_acc = {dbl_acc[DBL_W-9:0], b};
					if (payload_cnt >= DBL_LAST) begin
						r.value_kind  = KIND_DOUBLE;
						r.double_bits = dbl_acc;
						settle(r, last);
					end else begin
						payload_cnt = payload_cnt + CNT_W'(1);
						if (last) begin
							r.cut_short = 1'b1;
							settle(r, 1'b1);
						end
					end
				end
				default: begin
					if (last)
						cur_phase = PH_TYPE;
				end
			endcase
		endfunction

		// Compare one accepted result beat with the oldest predicted value.
		function void check_value(result_t got);
			result_t want;
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result beat kind=%0d int=%h dbl=%h cut=%b",
					$time, got.value_kind, got.int_value, got.double_bits, got.cut_short);
				mismatches++;
				return;
			end
			want = pending_values.pop_front();
			if (got.value_kind !== want.value_kind) begin
				$display("%0t: value_kind expected %0d got %0d",
					$time, want.value_kind, got.value_kind);
				mismatches++;
			end
			if (got.int_value !== want.int_value) begin
				$display("%0t: int_value expected %h got %h",
					$time, want.int_value, got.int_value);
				mismatches++;
			end
			if (got.double_bits !== want.double_bits) begin
				$display("%0t: double_bits expected %h got %h",
					$time, want.double_bits, got.double_bits);
				mismatches++;
			end
			if (got.cut_short !== want.cut_short) begin
				$display("%0t: cut_short expected %b got %b",
					$time, want.cut_short, got.cut_short);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;   // [7:0] data_byte
	logic                   s_tlast = 1'b0; // last_byte
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;        // [2:0] value_kind, [31:3] int_value,
	                                        // [95:32] double_bits
	logic                   m_tuser;        // cut_short

	decoded_value_book book = new();

	logic [7:0] msg_q[$];      // bytes of the message being built
	bit         steady = 1'b0; // no random gaps on either side while set
	bit         hold_req = 1'b0;
	int         idle_cycles = 0;

	amf3_scalar_value_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Gap before a beat: none while steady; else mostly back-to-back, sometimes short, rarely long.
	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Offer one byte after a random gap; hold it until the beat is taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		book.take_byte(b, last);
	endtask

	// Send the built message with tlast on its final byte, then clear it.
	task automatic send_queued();
		for (int i = 0; i < msg_q.size(); i++)
			send_byte(msg_q[i], i == msg_q.size() - 1);
		msg_q.delete();
	endtask

	// Hold the sender until every predicted value has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (book.pending_count() != 0) @(posedge clk);
	endtask

	// Build one random message; return the number of bytes in it.
	task automatic build_random(output int body_len);
		int         sel;
		int         plen;
		logic [7:0] b;
		if ($urandom_range(0, 99) < 15) begin
			// noise: arbitrary bytes, any framing
			plen = $urandom_range(1, 6);
			repeat (plen) msg_q.push_back(8'($urandom_range(0, 255)));
			body_len = plen;
			return;
		end
		sel = $urandom_range(0, 11);
		case (sel)
			0, 1, 2, 3: msg_q.push_back(8'(sel));
			4, 5, 6:    msg_q.push_back(MARK_INT);
			7, 8, 9:    msg_q.push_back(MARK_DBL);
			default:    msg_q.push_back(8'($urandom_range(6, 255)));
		endcase
		plen = 0;
		if (msg_q[0] == MARK_INT) begin
			plen = $urandom_range(1, 4);
			for (int i = 0; i < plen; i++) begin
				b = 8'($urandom_range(0, 255));
				// set continuation bits so the integer ends where planned
				if (i < U29_GROUPS)
					b[7] = (i < plen - 1);
				msg_q.push_back(b);
			end
		end else if (msg_q[0] == MARK_DBL) begin
			plen = DBL_LAST + 1;
			repeat (plen) msg_q.push_back(8'($urandom_range(0, 255)));
		end
		if (plen > 0 && $urandom_range(0, 9) == 0) begin
			// drop the tail of the payload so the message ends inside the value
			repeat ($urandom_range(1, plen)) void'(msg_q.pop_back());
			body_len = msg_q.size();
		end else begin
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
			body_len = msg_q.size();
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Check every result beat taken.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.value_kind  = kind_t'(m_tdata[KIND_W-1:0]);
			got.int_value   = m_tdata[KIND_W +: INT_W];
			got.double_bits = m_tdata[KIND_W + INT_W +: DBL_W];
			got.cut_short   = m_tuser;
			book.check_value(got);
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int body_len;
		int sent;
		int n_msgs;
		bit hold_done;
		bit pause_done;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every marker, alone and truncated, extreme payloads.
		msg_q = '{8'h00};                    send_queued();
		msg_q = '{8'h01};                    send_queued();
		msg_q = '{MARK_FALSE};               send_queued();
		msg_q = '{MARK_TRUE};                send_queued();
		msg_q = '{MARK_INT};                 send_queued();
		msg_q = '{MARK_DBL};                 send_queued();
		msg_q = '{8'hFF, 8'h80};             send_queued(); // unknown marker, payload skipped
		msg_q = '{MARK_INT, 8'h00, 8'h55};   send_queued(); // zero, then skip
		msg_q = '{MARK_INT, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_queued();                                      // largest U29
		msg_q = '{MARK_INT, 8'h80};          send_queued(); // ends inside integer
		msg_q = '{MARK_DBL, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
		send_queued();
		wait_drained();

		// Random messages, mostly well formed.
		sent = 0;
		n_msgs = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (sent < RANDOM_BYTES) begin
			if (n_msgs % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (!hold_done && sent > RANDOM_BYTES / 3) begin
				// stall the receiver and keep offering so the block backs up
				steady = 1'b1;
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && sent > 2 * RANDOM_BYTES / 3) begin
				wait_drained();
				pause_done = 1'b1;
			end
			build_random(body_len);
			send_queued();
			sent += body_len;
			n_msgs++;
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (book.pending_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
